// File: rtl/oaht_pkg.sv
// Package for the open-address hash table: payload and control structs, codes and constants.
// Used by every module of the block; depends on nothing.
package oaht_pkg;

   localparam int MAX_SLOTS_DEFAULT = 1024;
   localparam int KEY_BYTES = 8;
   localparam int KEY_W = 64;
   localparam int VAL_W = 32;
   localparam int HASH_W = 32;
   localparam int INIT_SIZE_W = 11;
   localparam int THRESH_W = 9;
   localparam int CSR_DATA_W = 11;

   localparam logic [INIT_SIZE_W-1:0] INIT_SIZE_RESET = 11'd10;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 9'd192;

   localparam logic [0:0] CSR_INIT_SIZE = 1'b0;
   localparam logic [0:0] CSR_THRESHOLD = 1'b1;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_DELETE = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;
   localparam logic [1:0] OP_NOP = 2'd3;

   localparam logic [1:0] STS_OK = 2'd0;
   localparam logic [1:0] STS_ABSENT = 2'd1;
   localparam logic [1:0] STS_FULL = 2'd2;

   localparam logic [1:0] SLOT_EMPTY = 2'd0;
   localparam logic [1:0] SLOT_LIVE = 2'd1;
   localparam logic [1:0] SLOT_TOMB = 2'd2;

   localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

   localparam logic [3:0] MEM_NONE = 4'd0;
   localparam logic [3:0] MEM_CLR = 4'd1;
   localparam logic [3:0] MEM_PROBE_RD = 4'd2;
   localparam logic [3:0] MEM_RH_CLR = 4'd3;
   localparam logic [3:0] MEM_RH_RD_OLD = 4'd4;
   localparam logic [3:0] MEM_RH_RD_NEW = 4'd5;
   localparam logic [3:0] MEM_RH_PUT = 4'd6;
   localparam logic [3:0] MEM_INS_HIT = 4'd7;
   localparam logic [3:0] MEM_INS_NEW = 4'd8;
   localparam logic [3:0] MEM_DEL = 4'd9;

   typedef struct packed {
      logic [1:0] opcode;
      logic [KEY_W-1:0] key;
      logic signed [VAL_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] result_value;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic div_start;
      logic div_rh;
      logic walk_init;
      logic probe_step;
      logic rh_begin;
      logic rh_latch;
      logic rh_next;
      logic rh_init_idx;
      logic rh_step;
      logic commit;
      logic count_inc;
      logic count_dec;
      logic rsp_load;
      logic [3:0] mem_op;
   } cmd_type;

   typedef struct packed {
      logic cfg_clear;
      logic clr_last;
      logic rh_clr_last;
      logic need_double;
      logic div_done;
      logic walk_last;
      logic old_live;
      logic new_empty;
      logic rh_cap;
      logic scan_last;
      logic [1:0] op;
      logic hit_found;
      logic spot_found;
      logic rsp_free;
   } sts_type;

endpackage

// File: rtl/oaht_div.sv
// Iterative restoring divider that returns the remainder of a hash by a slot count.
// One quotient bit per cycle; depends on oaht_pkg.
module oaht_div #(
   parameter int SIZE_W = 12,
   parameter int IDX_W = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [oaht_pkg::HASH_W-1:0] dividend,
   input  logic [SIZE_W-1:0]           divisor,
   output logic                        done,
   output logic [IDX_W-1:0]            remainder
);
   import oaht_pkg::*;

   localparam int CNT_W = $clog2(HASH_W);

   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [SIZE_W-1:0] dvs_ff, dvs_in;
   logic [HASH_W-1:0] dvd_ff, dvd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [SIZE_W:0]   trial;

   always_comb begin
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      dvd_in = dvd_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      trial = {rem_ff, dvd_ff[HASH_W-1]};
      if (start) begin
         rem_in = '0;
         dvs_in = divisor;
         dvd_in = dividend;
         cnt_in = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = SIZE_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[SIZE_W-1:0];
         end
         dvd_in = {dvd_ff[HASH_W-2:0], 1'b0};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(HASH_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      dvd_ff <= dvd_in;
   end

   assign done = done_ff;
   assign remainder = rem_ff[IDX_W-1:0];

endmodule

// File: rtl/oaht_dp.sv
// Datapath of the hash table: configuration, slot memories, probe and rehash registers,
// the remainder divider and the result register. Depends on oaht_pkg and oaht_div.
module oaht_dp #(
   parameter int MAX_SLOTS = oaht_pkg::MAX_SLOTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  oaht_pkg::req_type               req_payload,
   input  logic                            csr_write,
   input  logic [0:0]                      csr_index,
   input  logic [oaht_pkg::CSR_DATA_W-1:0] csr_data,
   input  oaht_pkg::cmd_type               cmd,
   output oaht_pkg::sts_type               sts,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output oaht_pkg::rsp_type               rsp_payload
);
   import oaht_pkg::*;

   localparam int IW = $clog2(MAX_SLOTS);
   localparam int SW = $clog2(MAX_SLOTS + 1);
   localparam int AW = IW + 1;
   localparam int XW = (SW > INIT_SIZE_W) ? SW : INIT_SIZE_W;
   localparam int PW = SW + THRESH_W;

   function automatic logic [HASH_W-1:0] key_hash(input logic [KEY_W-1:0] k);
      logic [HASH_W-1:0] h;
      logic              alive;
      logic [7:0]        b;
      h = '0;
      alive = 1'b1;
      for (int n = 0; n < 8; n++) begin
         b = k[KEY_W-1-8*n -: 8];
         if (b == 8'd0 || n >= KEY_BYTES) alive = 1'b0;
         if (alive) h = {h[HASH_W-6:0], 5'b0} + HASH_W'(b);
      end
      return h;
   endfunction

   function automatic logic [KEY_W-1:0] canon_key(input logic [KEY_W-1:0] k);
      logic [KEY_W-1:0] c;
      logic             alive;
      logic [7:0]       b;
      c = '0;
      alive = 1'b1;
      for (int n = 0; n < 8; n++) begin
         b = k[KEY_W-1-8*n -: 8];
         if (b == 8'd0 || n >= KEY_BYTES) alive = 1'b0;
         if (alive) c[KEY_W-1-8*n -: 8] = b;
      end
      return c;
   endfunction

   function automatic logic [SW-1:0] clamp_size(input logic [INIT_SIZE_W-1:0] s);
      logic [XW-1:0] w;
      w = XW'(s);
      if (w == '0) return SW'(1);
      else if (w > XW'(MAX_SLOTS)) return SW'(MAX_SLOTS);
      else return SW'(w);
   endfunction

   function automatic logic [IW-1:0] next_idx(input logic [IW-1:0] idx,
                                              input logic [SW-1:0] step,
                                              input logic [SW:0] sz);
      logic [SW+1:0] sum;
      sum = (SW+2)'(idx) + (SW+2)'(step) + (SW+2)'(1);
      if (sum >= (SW+2)'(sz)) sum = sum - (SW+2)'(sz);
      return sum[IW-1:0];
   endfunction

   logic [THRESH_W-1:0]    thresh_ff;
   logic                   bank_ff;
   logic [SW-1:0]          size_ff;
   logic [SW-1:0]          count_ff;
   logic [IW-1:0]          clr_ff;
   logic [1:0]             op_ff;
   logic [KEY_W-1:0]       key_ff;
   logic [HASH_W-1:0]      hash_ff;
   logic [VAL_W-1:0]       val_ff;
   logic [IW-1:0]          idx_ff;
   logic [SW-1:0]          step_ff;
   logic                   hit_ff;
   logic                   spot_ff;
   logic [IW-1:0]          hit_idx_ff;
   logic [IW-1:0]          spot_idx_ff;
   logic [VAL_W-1:0]       hit_val_ff;
   logic [IW-1:0]          scan_ff;
   logic [KEY_W-1:0]       rkey_ff;
   logic [VAL_W-1:0]       rval_ff;
   logic [HASH_W-1:0]      rhash_ff;
   logic                   rsp_valid_ff;
   rsp_type                rsp_ff, rsp_in;
   logic [1:0]             st_rd_ff;
   logic [KEY_W-1:0]       key_rd_ff;
   logic [VAL_W-1:0]       val_rd_ff;

   logic [1:0]       st_mem [2**AW];
   logic [KEY_W-1:0] key_mem [2**AW];
   logic [VAL_W-1:0] val_mem [2**AW];

   logic [AW-1:0]    mem_addr;
   logic             st_we, key_we, val_we;
   logic [1:0]       st_wd;
   logic [KEY_W-1:0] key_wd;
   logic [VAL_W-1:0] val_wd;

   logic [SW:0]       nsize;
   logic              is_empty, is_tomb, is_match;
   logic [PW-1:0]     load_lhs, load_rhs;
   logic [HASH_W-1:0] div_dividend;
   logic [SW:0]       div_divisor;
   logic              div_done;
   logic [IW-1:0]     div_rem;

   assign nsize = {size_ff, 1'b0};
   assign is_empty = (st_rd_ff == SLOT_EMPTY);
   assign is_tomb = (st_rd_ff == SLOT_TOMB);
   assign is_match = (st_rd_ff == SLOT_LIVE) && (key_rd_ff == key_ff);
   assign load_lhs = PW'({count_ff, 8'b0});
   assign load_rhs = PW'(thresh_ff) * PW'(size_ff);
   assign div_dividend = cmd.div_rh ? rhash_ff : hash_ff;
   assign div_divisor = cmd.div_rh ? nsize : {1'b0, size_ff};

   oaht_div #(
      .SIZE_W (SW + 1),
      .IDX_W  (IW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      mem_addr = {bank_ff, idx_ff};
      st_we = 1'b0;
      key_we = 1'b0;
      val_we = 1'b0;
      st_wd = SLOT_EMPTY;
      key_wd = key_ff;
      val_wd = val_ff;
      case (cmd.mem_op)
         MEM_CLR: begin
            mem_addr = {1'b0, clr_ff};
            st_we = 1'b1;
         end
         MEM_PROBE_RD: mem_addr = {bank_ff, idx_ff};
         MEM_RH_CLR: begin
            mem_addr = {~bank_ff, clr_ff};
            st_we = 1'b1;
         end
         MEM_RH_RD_OLD: mem_addr = {bank_ff, scan_ff};
         MEM_RH_RD_NEW: mem_addr = {~bank_ff, idx_ff};
         MEM_RH_PUT: begin
            mem_addr = {~bank_ff, idx_ff};
            st_we = 1'b1;
            key_we = 1'b1;
            val_we = 1'b1;
            st_wd = SLOT_LIVE;
            key_wd = rkey_ff;
            val_wd = rval_ff;
         end
         MEM_INS_HIT: begin
            mem_addr = {bank_ff, hit_idx_ff};
            val_we = 1'b1;
         end
         MEM_INS_NEW: begin
            mem_addr = {bank_ff, spot_idx_ff};
            st_we = 1'b1;
            key_we = 1'b1;
            val_we = 1'b1;
            st_wd = SLOT_LIVE;
         end
         MEM_DEL: begin
            mem_addr = {bank_ff, hit_idx_ff};
            st_we = 1'b1;
            st_wd = SLOT_TOMB;
         end
         default: mem_addr = {bank_ff, idx_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (st_we) st_mem[mem_addr] <= st_wd;
      if (key_we) key_mem[mem_addr] <= key_wd;
      if (val_we) val_mem[mem_addr] <= val_wd;
      st_rd_ff <= st_mem[mem_addr];
      key_rd_ff <= key_mem[mem_addr];
      val_rd_ff <= val_mem[mem_addr];
   end

   always_comb begin
      rsp_in.result_value = MISS_VALUE;
      rsp_in.status = STS_OK;
      case (op_ff)
         OP_INSERT: if (!hit_ff && !spot_ff) rsp_in.status = STS_FULL;
         OP_DELETE: if (!hit_ff) rsp_in.status = STS_ABSENT;
         OP_SEARCH: begin
            if (hit_ff) rsp_in.result_value = hit_val_ff;
            else rsp_in.status = STS_ABSENT;
         end
         default: rsp_in.status = STS_OK;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
         bank_ff <= 1'b0;
         size_ff <= clamp_size(INIT_SIZE_RESET);
         count_ff <= '0;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write && csr_index == CSR_THRESHOLD) thresh_ff <= csr_data[THRESH_W-1:0];
         if (csr_write && csr_index == CSR_INIT_SIZE) begin
            bank_ff <= 1'b0;
            size_ff <= clamp_size(csr_data);
            count_ff <= '0;
            clr_ff <= '0;
         end else begin
            if (cmd.rh_begin) clr_ff <= '0;
            else if (cmd.mem_op == MEM_CLR || cmd.mem_op == MEM_RH_CLR) begin
               clr_ff <= clr_ff + IW'(1);
            end
            if (cmd.commit) begin
               bank_ff <= ~bank_ff;
               size_ff <= nsize[SW-1:0];
            end
            if (cmd.count_inc) count_ff <= count_ff + SW'(1);
            else if (cmd.count_dec && count_ff != '0) count_ff <= count_ff - SW'(1);
         end
         if (cmd.rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) rsp_ff <= rsp_in;
      if (cmd.accept) begin
         op_ff <= req_payload.opcode;
         key_ff <= canon_key(req_payload.key);
         hash_ff <= key_hash(req_payload.key);
         val_ff <= req_payload.value;
      end
      if (cmd.accept || cmd.walk_init) begin
         hit_ff <= 1'b0;
         spot_ff <= 1'b0;
      end else if (cmd.probe_step) begin
         if ((is_empty || is_tomb) && !spot_ff) begin
            spot_ff <= 1'b1;
            spot_idx_ff <= idx_ff;
         end
         if (is_match) begin
            hit_ff <= 1'b1;
            hit_idx_ff <= idx_ff;
            hit_val_ff <= val_rd_ff;
         end
      end
      if (cmd.walk_init || cmd.rh_init_idx) begin
         idx_ff <= div_rem;
         step_ff <= '0;
      end else if (cmd.probe_step) begin
         idx_ff <= next_idx(idx_ff, step_ff, {1'b0, size_ff});
         step_ff <= step_ff + SW'(1);
      end else if (cmd.rh_step) begin
         idx_ff <= next_idx(idx_ff, step_ff, nsize);
         step_ff <= step_ff + SW'(1);
      end
      if (cmd.rh_begin) scan_ff <= '0;
      else if (cmd.rh_next) scan_ff <= scan_ff + IW'(1);
      if (cmd.rh_latch) begin
         rkey_ff <= key_rd_ff;
         rval_ff <= val_rd_ff;
         rhash_ff <= key_hash(key_rd_ff);
      end
   end

   always_comb begin
      sts.cfg_clear = csr_write && (csr_index == CSR_INIT_SIZE);
      sts.clr_last = (clr_ff == IW'(MAX_SLOTS - 1));
      sts.rh_clr_last = ((SW+1)'(clr_ff) + (SW+1)'(1)) == nsize;
      sts.need_double = (load_lhs >= load_rhs) && (nsize <= (SW+1)'(MAX_SLOTS));
      sts.div_done = div_done;
      sts.walk_last = is_empty || is_match ||
                      (((SW+1)'(step_ff) + (SW+1)'(1)) == {1'b0, size_ff});
      sts.old_live = (st_rd_ff == SLOT_LIVE);
      sts.new_empty = is_empty;
      sts.rh_cap = ((SW+1)'(step_ff) + (SW+1)'(1)) == nsize;
      sts.scan_last = ((SW+1)'(scan_ff) + (SW+1)'(1)) == {1'b0, size_ff};
      sts.op = op_ff;
      sts.hit_found = hit_ff;
      sts.spot_found = spot_ff;
      sts.rsp_free = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: rtl/oaht_ctrl.sv
// Controller of the hash table: sequences table clearing, doubling with rehash,
// probe walks, slot updates and the result handoff. Depends on oaht_pkg.
module oaht_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  oaht_pkg::sts_type sts,
   output oaht_pkg::cmd_type cmd
);
   import oaht_pkg::*;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_CHECK = 4'd2;
   localparam logic [3:0] S_RH_CLR = 4'd3;
   localparam logic [3:0] S_RH_RD = 4'd4;
   localparam logic [3:0] S_RH_EV = 4'd5;
   localparam logic [3:0] S_RH_DS = 4'd6;
   localparam logic [3:0] S_RH_DIV = 4'd7;
   localparam logic [3:0] S_RH_PRD = 4'd8;
   localparam logic [3:0] S_RH_PEV = 4'd9;
   localparam logic [3:0] S_WALK_DS = 4'd10;
   localparam logic [3:0] S_DIV = 4'd11;
   localparam logic [3:0] S_PRD = 4'd12;
   localparam logic [3:0] S_PEV = 4'd13;
   localparam logic [3:0] S_APPLY = 4'd14;
   localparam logic [3:0] S_RESP = 4'd15;

   logic [3:0] state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd = '0;
      cmd.mem_op = MEM_NONE;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.mem_op = MEM_CLR;
            if (sts.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (sts.op == OP_NOP) begin
               state_in = S_RESP;
            end else if (sts.op == OP_INSERT && sts.need_double) begin
               cmd.rh_begin = 1'b1;
               state_in = S_RH_CLR;
            end else begin
               cmd.div_start = 1'b1;
               state_in = S_DIV;
            end
         end
         S_RH_CLR: begin
            cmd.mem_op = MEM_RH_CLR;
            if (sts.rh_clr_last) state_in = S_RH_RD;
         end
         S_RH_RD: begin
            cmd.mem_op = MEM_RH_RD_OLD;
            state_in = S_RH_EV;
         end
         S_RH_EV: begin
            if (sts.old_live) begin
               cmd.rh_latch = 1'b1;
               state_in = S_RH_DS;
            end else if (sts.scan_last) begin
               cmd.commit = 1'b1;
               state_in = S_WALK_DS;
            end else begin
               cmd.rh_next = 1'b1;
               state_in = S_RH_RD;
            end
         end
         S_RH_DS: begin
            cmd.div_start = 1'b1;
            cmd.div_rh = 1'b1;
            state_in = S_RH_DIV;
         end
         S_RH_DIV: begin
            cmd.div_rh = 1'b1;
            if (sts.div_done) begin
               cmd.rh_init_idx = 1'b1;
               state_in = S_RH_PRD;
            end
         end
         S_RH_PRD: begin
            cmd.mem_op = MEM_RH_RD_NEW;
            state_in = S_RH_PEV;
         end
         S_RH_PEV: begin
            if (sts.new_empty) begin
               cmd.mem_op = MEM_RH_PUT;
               if (sts.scan_last) begin
                  cmd.commit = 1'b1;
                  state_in = S_WALK_DS;
               end else begin
                  cmd.rh_next = 1'b1;
                  state_in = S_RH_RD;
               end
            end else if (sts.rh_cap) begin
               state_in = S_WALK_DS;
            end else begin
               cmd.rh_step = 1'b1;
               state_in = S_RH_PRD;
            end
         end
         S_WALK_DS: begin
            cmd.div_start = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (sts.div_done) begin
               cmd.walk_init = 1'b1;
               state_in = S_PRD;
            end
         end
         S_PRD: begin
            cmd.mem_op = MEM_PROBE_RD;
            state_in = S_PEV;
         end
         S_PEV: begin
            cmd.probe_step = 1'b1;
            if (sts.walk_last) state_in = S_APPLY;
            else state_in = S_PRD;
         end
         S_APPLY: begin
            if (sts.op == OP_INSERT) begin
               if (sts.hit_found) begin
                  cmd.mem_op = MEM_INS_HIT;
               end else if (sts.spot_found) begin
                  cmd.mem_op = MEM_INS_NEW;
                  cmd.count_inc = 1'b1;
               end
            end else if (sts.op == OP_DELETE && sts.hit_found) begin
               cmd.mem_op = MEM_DEL;
               cmd.count_dec = 1'b1;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (sts.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
      if (sts.cfg_clear) state_in = S_CLEAR;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/open_address_hash_table.sv
// Key/value table with open addressing and triangular probing, made of a controller
// and a datapath. A no-operation skips the divide and the probe walk. The remainder of
// the 32-bit key hash by the slot count comes from a one-bit-per-cycle divider, and
// each probe is one read of the single-port slot memory. An insert that first doubles
// the table adds the clearing of the new bank (one cycle per new slot), a read of each
// old slot and a divide plus probe walk per live entry. After reset and after every
// write of the size register the block clears MAX_SLOTS status entries, one per cycle,
// before it takes a word; results wait in an output register.
module open_address_hash_table #(
   parameter int MAX_SLOTS = oaht_pkg::MAX_SLOTS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  oaht_pkg::req_type               req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output oaht_pkg::rsp_type               rsp_payload,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [0:0]                      csr_index,
   input  logic [oaht_pkg::CSR_DATA_W-1:0] csr_data
);
   import oaht_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   oaht_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   oaht_dp #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: tb/sv/open_address_hash_table_tb.sv
// Self-checking testbench for open_address_hash_table: directed and random insert,
// delete, search and no-operation words under several table sizes, thresholds and
// handshake stalls. Depends on oaht_pkg and the open_address_hash_table RTL.
module open_address_hash_table_tb;
   import oaht_pkg::*;

   class hash_table_board;
      logic [KEY_W-1:0] keys [2*MAX_SLOTS_DEFAULT];
      logic [VAL_W-1:0] vals [2*MAX_SLOTS_DEFAULT];
      logic [1:0] slot_state [2*MAX_SLOTS_DEFAULT];
      int unsigned bank, slots, entries, init_size, threshold;
      rsp_type expected_q [$];
      int errors;

      function void clear_table();
         foreach (slot_state[i]) slot_state[i] = SLOT_EMPTY;
         bank = 0;
         entries = 0;
         slots = (init_size == 0) ? 1 : (init_size > MAX_SLOTS_DEFAULT) ?
                 MAX_SLOTS_DEFAULT : init_size;
      endfunction

      function void power_up();
         init_size = INIT_SIZE_RESET;
         threshold = THRESH_RESET;
         errors = 0;
         clear_table();
      endfunction

      function void write_reg(logic [0:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_INIT_SIZE) begin
            init_size = data;
            clear_table();
         end else begin
            threshold = data[THRESH_W-1:0];
         end
      endfunction

      function logic [KEY_W-1:0] canon(logic [KEY_W-1:0] k, output logic [HASH_W-1:0] h);
         logic [KEY_W-1:0] out;
         logic [7:0] b;
         out = '0;
         h = '0;
         for (int i = 0; i < KEY_BYTES; i++) begin
            b = k[63-8*i -: 8];
            if (b == 0) break;
            out[63-8*i -: 8] = b;
            h = (h << 5) + b;
         end
         return out;
      endfunction

      function void walk(logic [KEY_W-1:0] k, logic [HASH_W-1:0] h,
                         output int hit, output int spot);
         int unsigned base, idx;
         base = bank * MAX_SLOTS_DEFAULT;
         idx = h % slots;
         hit = -1;
         spot = -1;
         for (int unsigned i = 0; i < slots; i++) begin
            if (slot_state[base+idx] == SLOT_EMPTY) begin
               if (spot < 0) spot = idx;
               return;
            end
            if (slot_state[base+idx] == SLOT_TOMB) begin
               if (spot < 0) spot = idx;
            end else if (keys[base+idx] == k) begin
               hit = idx;
               return;
            end
            idx = (idx + i + 1) % slots;
         end
      endfunction

      function void try_double();
         int unsigned nsize, obase, nbase, idx;
         logic [HASH_W-1:0] h;
         bit placed;
         nsize = slots * 2;
         obase = bank * MAX_SLOTS_DEFAULT;
         nbase = (bank ^ 1) * MAX_SLOTS_DEFAULT;
         if (nsize > MAX_SLOTS_DEFAULT) return;
         for (int i = 0; i < MAX_SLOTS_DEFAULT; i++) slot_state[nbase+i] = SLOT_EMPTY;
         for (int unsigned s = 0; s < slots; s++) begin
            if (slot_state[obase+s] != SLOT_LIVE) continue;
            void'(canon(keys[obase+s], h));
            idx = h % nsize;
            placed = 0;
            for (int unsigned i = 0; i < nsize; i++) begin
               if (slot_state[nbase+idx] == SLOT_EMPTY) begin
                  slot_state[nbase+idx] = SLOT_LIVE;
                  keys[nbase+idx] = keys[obase+s];
                  vals[nbase+idx] = vals[obase+s];
                  placed = 1;
                  break;
               end
               idx = (idx + i + 1) % nsize;
            end
            if (!placed) return;
         end
         bank ^= 1;
         slots = nsize;
      endfunction

      function void note_request(req_type w);
         logic [HASH_W-1:0] h;
         logic [KEY_W-1:0] k;
         int hit, spot, base;
         rsp_type r;
         r.result_value = MISS_VALUE;
         r.status = STS_OK;
         k = canon(w.key, h);
         if (w.opcode == OP_INSERT) begin
            if (longint'(entries) * 256 >= longint'(threshold) * slots) try_double();
            base = bank * MAX_SLOTS_DEFAULT;
            walk(k, h, hit, spot);
            if (hit >= 0) begin
               vals[base+hit] = w.value;
            end else if (spot >= 0) begin
               slot_state[base+spot] = SLOT_LIVE;
               keys[base+spot] = k;
               vals[base+spot] = w.value;
               entries++;
            end else begin
               r.status = STS_FULL;
            end
         end else if (w.opcode == OP_DELETE) begin
            base = bank * MAX_SLOTS_DEFAULT;
            walk(k, h, hit, spot);
            if (hit >= 0) begin
               slot_state[base+hit] = SLOT_TOMB;
               if (entries > 0) entries--;
            end else begin
               r.status = STS_ABSENT;
            end
         end else if (w.opcode == OP_SEARCH) begin
            base = bank * MAX_SLOTS_DEFAULT;
            walk(k, h, hit, spot);
            if (hit >= 0) r.result_value = vals[base+hit];
            else r.status = STS_ABSENT;
         end
         expected_q.push_back(r);
      endfunction

      function void check_response(rsp_type got);
         rsp_type exp;
         if (expected_q.size() == 0) begin
            $error("unexpected result word %h", got);
            errors++;
            return;
         end
         exp = expected_q.pop_front();
         if (got.result_value !== exp.result_value) begin
            $error("result_value expected %0d actual %0d", exp.result_value, got.result_value);
            errors++;
         end
         if (got.status !== exp.status) begin
            $error("status expected %0d actual %0d", exp.status, got.status);
            errors++;
         end
      endfunction
   endclass

   localparam int WATCHDOG_LIMIT = 300000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   rsp_type rsp_payload;
   logic csr_valid = 0;
   logic csr_ready;
   logic [0:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   hash_table_board board = new();
   int tx_idle_pct = 0;
   int rx_stall_pct = 0;
   bit hold_request = 0;
   int hold_left = 0;
   int quiet_cycles = 0;
   logic [KEY_W-1:0] key_pool [$];

   open_address_hash_table u_top (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_response(rsp_payload);
      if (hold_request) begin
         hold_left = 400;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_word(req_type w);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(w);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.expected_q.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.write_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [KEY_W-1:0] fresh_key();
      logic [KEY_W-1:0] k;
      int len;
      k = {$urandom, $urandom};
      len = $urandom_range(8);
      for (int i = 0; i < len; i++)
         if (k[63-8*i -: 8] == 0) k[63-8*i -: 8] = 8'($urandom_range(255, 1));
      if (len < 8) k[63-8*len -: 8] = 8'h00;
      return k;
   endfunction

   function automatic logic [KEY_W-1:0] pool_key();
      logic [KEY_W-1:0] k;
      k = key_pool[$urandom_range(key_pool.size() - 1)];
      // Bytes after the terminator are ignored, so scramble them.
      for (int i = 0; i < 8; i++) begin
         if (k[63-8*i -: 8] == 0) begin
            for (int j = i + 1; j < 8; j++) k[63-8*j -: 8] = 8'($urandom);
            break;
         end
      end
      return k;
   endfunction

   task automatic run_random(int count, int pool_size);
      req_type w;
      int pick;
      key_pool.delete();
      for (int i = 0; i < pool_size; i++) key_pool.push_back(fresh_key());
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         w.opcode = (pick < 45) ? OP_INSERT : (pick < 65) ? OP_DELETE :
                    (pick < 95) ? OP_SEARCH : OP_NOP;
         w.key = ($urandom_range(99) < 85) ? pool_key() : fresh_key();
         w.value = $urandom;
         send_word(w);
      end
   endtask

   task automatic send_op(logic [1:0] op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
      req_type w;
      w.opcode = op;
      w.key = k;
      w.value = v;
      send_word(w);
   endtask

   initial begin
      board.power_up();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_op(OP_INSERT, 64'h0, 32'h8000_0000);
      send_op(OP_SEARCH, 64'h00FF_FFFF_FFFF_FFFF, 32'h0);
      send_op(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h7FFF_FFFF);
      send_op(OP_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
      send_op(OP_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0000);
      send_op(OP_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 32'h1234_5678);
      send_op(OP_INSERT, 64'h4142_4300_DEAD_BEEF, 32'h55AA_55AA);
      send_op(OP_SEARCH, 64'h4142_4300_0000_0001, 32'h0);
      send_op(OP_DELETE, 64'h4142_4400_0000_0000, 32'h0);
      send_op(OP_DELETE, 64'h4142_4300_FFFF_FFFF, 32'h0);
      send_op(OP_SEARCH, 64'h4142_4300_0000_0000, 32'h0);
      send_op(OP_INSERT, 64'h4142_4300_0000_0000, 32'hAAAA_5555);
      send_op(OP_SEARCH, 64'h4142_4300_0000_0000, 32'h0);
      send_op(OP_NOP, 64'h4142_4300_0000_0000, 32'hFFFF_FFFF);
      send_op(OP_DELETE, 64'h0, 32'h0);
      send_op(OP_SEARCH, 64'h0, 32'h0);
      send_op(OP_INSERT, 64'h8081_FE7F_0102_0304, 32'h0000_0001);
      send_op(OP_SEARCH, 64'h8081_FE7F_0102_0304, 32'h0);
      run_random(130, 12);
      wait_drained();

      write_csr(CSR_THRESHOLD, 11'd0);
      write_csr(CSR_INIT_SIZE, 11'd0);
      tx_idle_pct = 53;
      run_random(150, 30);
      wait_drained();

      write_csr(CSR_INIT_SIZE, 11'd2047);
      write_csr(CSR_THRESHOLD, 11'd256);
      tx_idle_pct = 0;
      rx_stall_pct = 53;
      run_random(150, 40);
      wait_drained();

      write_csr(CSR_INIT_SIZE, 11'd3);
      write_csr(CSR_THRESHOLD, 11'h7FF);
      tx_idle_pct = 9;
      rx_stall_pct = 9;
      run_random(150, 8);
      wait_drained();

      write_csr(CSR_INIT_SIZE, 11'd7);
      write_csr(CSR_THRESHOLD, 11'd1);
      tx_idle_pct = 0;
      rx_stall_pct = 0;
      hold_request = 1;
      run_random(150, 20);
      wait_drained();

      write_csr(CSR_INIT_SIZE, 11'd1024);
      write_csr(CSR_THRESHOLD, 11'd128);
      tx_idle_pct = 53;
      run_random(140, 25);
      wait_drained();

      write_csr(CSR_INIT_SIZE, 11'd1);
      write_csr(CSR_THRESHOLD, 11'd255);
      tx_idle_pct = 0;
      rx_stall_pct = 53;
      run_random(140, 16);
      wait_drained();

      write_csr(CSR_INIT_SIZE, 11'd5);
      write_csr(CSR_THRESHOLD, 11'd192);
      tx_idle_pct = 9;
      rx_stall_pct = 9;
      run_random(140, 10);
      wait_drained();

      if (board.errors == 0 && board.expected_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule

// File: open_address_hash_table.f
rtl/oaht_pkg.sv
rtl/oaht_div.sv
rtl/oaht_dp.sv
rtl/oaht_ctrl.sv
rtl/open_address_hash_table.sv
tb/sv/open_address_hash_table_tb.sv
